>>> rtl/smx_pkg.sv
// shared types, constants and exponent table for the softmax row normalizer
package smx_pkg;

    localparam int LOGIT_W = 16;
    localparam int PROB_W  = 16;
    localparam int POS_W   = 6;
    localparam int WGT_W   = 16;
    localparam int TOTAL_W = 22;
    localparam int Q60_W   = 61;
    localparam int MAX_Q   = 11;
    localparam int TDATA_M_W = 24;

    typedef logic [Q60_W-1:0] q60_t;
    typedef q60_t exp_tbl_t [256];

    // controller to datapath commands
    typedef struct packed {
        logic in_ready;
        logic exp_start;
        logic wt_write;
        logic div_start;
        logic out_load;
        logic idx_inc;
        logic idx_clr;
        logic row_clear;
    } smx_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic row_done;
        logic exp_done;
        logic div_done;
        logic idx_last;
        logic out_free;
    } smx_status_t;

    // floor(a * b / 2^60), split in 30-bit halves
    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [63:0] ah, al, bh, bl, mid;
        ah  = a >> 30;
        al  = a & 64'h3FFF_FFFF;
        bh  = b >> 30;
        bl  = b & 64'h3FFF_FFFF;
        mid = ah * bl + al * bh + ((al * bl) >> 30);
        return ah * bh + (mid >> 30);
    endfunction

    // floor(n / d) by shift and subtract, for the small series divisors
    function automatic logic [63:0] div_small(logic [63:0] n, logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem    = rem - {1'b0, d};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-y) in q60 by its series up to the y^20 term, evaluated at elaboration only
    function automatic logic [63:0] exp_neg_q60(logic [63:0] y);
        logic [63:0] term, sum;
        term = 64'd1 << 60;
        sum  = 64'd1 << 60;
        for (logic [63:0] k = 1; k <= 20; k++) begin
            term = div_small(mul_q60(term, y), k);
            if (k[0]) begin
                sum = (term > sum) ? 64'd0 : sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic exp_tbl_t build_exp_tbl();
        exp_tbl_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = Q60_W'(exp_neg_q60(64'(i) << 52));
        end
        return t;
    endfunction

    // exp(-r/256) for the fractional part and exp(-1) for each whole step
    localparam exp_tbl_t EXP_FRAC = build_exp_tbl();
    localparam q60_t     EXP_ONE  = Q60_W'(exp_neg_q60(64'd1 << 60));

endpackage

>>> rtl/softmax_row_normalizer.sv
// top level of the softmax row normalizer
// Max-subtracted softmax over one row of signed Q8.8 logits. Logits are taken
// one per cycle until the item marked tlast; elements past ROW_CAPACITY are
// dropped and every result of that row carries tuser = 1. The row is then
// walked twice: a weight pass computes each exp(-(max-x)/256) in a multi-cycle
// unit that shares one 31x31 multiplier (one multiply by exp(-1) per whole unit
// of distance, at most 11 units), and a normalize pass runs a 17-step restoring
// divider to give unsigned Q0.16 probabilities in order. No input is taken
// during the two passes; the last result may still wait in the output register
// while the next row loads.
module softmax_row_normalizer #(
    parameter int ROW_CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // logit[15:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // probability[15:0], position[21:16], zero[23:22]
    output logic        m_tlast,
    output logic        m_tuser    // overflowed
);
    import smx_pkg::*;

    smx_cmd_t    cmd;
    smx_status_t status;

    smx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    smx_datapath #(.ROW_CAPACITY(ROW_CAPACITY)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    assign s_tready = cmd.in_ready;
endmodule

>>> rtl/smx_ram.sv
// generic single-write, single-read ram with registered read data
module smx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

>>> rtl/smx_exp_unit.sv
// fixed-point weight unit: exp(-d/256) scaled to 16 bits, one shared multiplier
module smx_exp_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [smx_pkg::LOGIT_W-1:0] gap,
    output logic                      done,
    output logic [smx_pkg::WGT_W-1:0] weight
);
    import smx_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [30:0] E1_HI = 31'(EXP_ONE >> 30);
    localparam logic [30:0] E1_LO = 31'(EXP_ONE[29:0]);

    logic [1:0]        state_reg;
    logic [2:0]        step_reg;
    logic [3:0]        cnt_reg;
    q60_t              v_reg;
    logic [61:0]       prod_reg;
    logic [62:0]       mid_reg;
    logic              done_reg;
    logic [WGT_W-1:0]  weight_reg;
    logic [30:0]       a_op;
    logic [30:0]       b_op;
    logic [7:0]        gap_q;
    logic [Q60_W:0]    rounded;

    assign gap_q   = gap[15:8];
    assign rounded = {1'b0, v_reg} + (Q60_W+1)'(64'd1 << 43);

    // operand selection for the four partial products
    always_comb begin
        case (step_reg)
            3'd0: begin a_op = v_reg[60:30];         b_op = E1_LO; end
            3'd1: begin a_op = {1'b0, v_reg[29:0]};  b_op = E1_HI; end
            3'd2: begin a_op = {1'b0, v_reg[29:0]};  b_op = E1_LO; end
            default: begin a_op = v_reg[60:30];      b_op = E1_HI; end
        endcase
    end

    // sequencer for the repeated q60 multiply by exp(-1)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        step_reg <= '0;
                        if (gap_q > 8'(MAX_Q)) begin
                            v_reg     <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_FIN;
                        end else begin
                            v_reg     <= EXP_FRAC[gap[7:0]];
                            cnt_reg   <= gap_q[3:0];
                            state_reg <= (gap_q == 8'd0) ? ST_FIN : ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    if (step_reg != 3'd4) begin
                        prod_reg <= a_op * b_op;
                    end
                    case (step_reg)
                        3'd1: mid_reg <= {1'b0, prod_reg};
                        3'd2: mid_reg <= mid_reg + {1'b0, prod_reg};
                        3'd3: mid_reg <= mid_reg + 63'(prod_reg >> 30);
                        3'd4: v_reg   <= Q60_W'(prod_reg + 62'(mid_reg >> 30));
                        default: mid_reg <= mid_reg;
                    endcase
                    if (step_reg == 3'd4) begin
                        step_reg <= '0;
                        cnt_reg  <= cnt_reg - 4'd1;
                        if (cnt_reg == 4'd1) begin
                            state_reg <= ST_FIN;
                        end
                    end else begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_FIN: begin
                    weight_reg <= (rounded[Q60_W:44] > (Q60_W-43)'(16'hFFFF)) ?
                                  16'hFFFF : rounded[59:44];
                    done_reg   <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign weight = weight_reg;
endmodule

>>> rtl/smx_datapath.sv
// datapath: row and weight stores, peak, sum, divider and output register
module smx_datapath #(
    parameter int ROW_CAPACITY = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  smx_pkg::smx_cmd_t            cmd,
    output smx_pkg::smx_status_t         status,
    input  logic                         s_tvalid,
    input  logic [smx_pkg::LOGIT_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [smx_pkg::TDATA_M_W-1:0] m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);
    import smx_pkg::*;

    localparam int CNT_W = $clog2(ROW_CAPACITY + 1);
    localparam int IDX_W = $clog2(ROW_CAPACITY);

    logic                  accept;
    logic                  store;
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic signed [LOGIT_W-1:0] peak_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic                  drop_reg;
    logic [LOGIT_W-1:0]    row_rd;
    logic [WGT_W-1:0]      wt_rd;
    logic [LOGIT_W:0]      diff;
    logic                  exp_done;
    logic [WGT_W-1:0]      exp_wgt;

    assign accept = s_tvalid & cmd.in_ready;
    assign store  = accept && (count_reg < CNT_W'(ROW_CAPACITY));
    assign diff   = {peak_reg[LOGIT_W-1], peak_reg} - {row_rd[LOGIT_W-1], row_rd};

    smx_ram #(.WIDTH(LOGIT_W), .DEPTH(ROW_CAPACITY)) u_row_ram (
        .aclk    (aclk),
        .wr_en   (store),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (idx_reg),
        .rd_data (row_rd)
    );

    smx_ram #(.WIDTH(WGT_W), .DEPTH(ROW_CAPACITY)) u_wt_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wt_write),
        .wr_addr (idx_reg),
        .wr_data (exp_wgt),
        .rd_addr (idx_reg),
        .rd_data (wt_rd)
    );

    smx_exp_unit u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.exp_start),
        .gap     (diff[LOGIT_W-1:0]),
        .done    (exp_done),
        .weight  (exp_wgt)
    );

    // row state: count, peak, sum, drop flag and walk index
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.row_clear) begin
            count_reg <= '0;
            peak_reg  <= {1'b1, {(LOGIT_W-1){1'b0}}};
            total_reg <= '0;
            drop_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (store) begin
                count_reg <= count_reg + CNT_W'(1);
                if ($signed(s_tdata) > peak_reg) begin
                    peak_reg <= $signed(s_tdata);
                end
            end else if (accept) begin
                drop_reg <= 1'b1;
            end
            if (cmd.wt_write) begin
                total_reg <= total_reg + TOTAL_W'(exp_wgt);
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [32:0]        dividend;
    logic [TOTAL_W:0]   rem_reg;
    logic [16:0]        shf_reg;
    logic [16:0]        quo_reg;
    logic [4:0]         dcnt_reg;
    logic               dbusy_reg;
    logic               ddone_reg;
    logic [TOTAL_W:0]   trial;
    logic               ge;

    assign dividend = {1'b0, wt_rd, 16'h0000} + 33'(total_reg >> 1);
    assign trial    = {rem_reg[TOTAL_W-1:0], shf_reg[16]};
    assign ge       = trial >= {1'b0, total_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else begin
            ddone_reg <= 1'b0;
            if (cmd.div_start) begin
                rem_reg   <= (TOTAL_W+1)'(dividend[32:17]);
                shf_reg   <= dividend[16:0];
                quo_reg   <= '0;
                dcnt_reg  <= 5'd17;
                dbusy_reg <= 1'b1;
            end else if (dbusy_reg) begin
                rem_reg  <= ge ? trial - {1'b0, total_reg} : trial;
                quo_reg  <= {quo_reg[15:0], ge};
                shf_reg  <= {shf_reg[15:0], 1'b0};
                dcnt_reg <= dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd1) begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
        end
    end

    // output register
    logic               mvalid_reg;
    logic [PROB_W-1:0]  prob_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               last_reg;
    logic               ovf_reg;
    logic               idx_last;

    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            prob_reg <= quo_reg[16] ? 16'hFFFF : quo_reg[15:0];
            pos_reg  <= POS_W'(idx_reg);
            last_reg <= idx_last;
            ovf_reg  <= drop_reg;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {2'b00, pos_reg, prob_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = ovf_reg;

    assign status.row_done = accept & s_tlast;
    assign status.exp_done = exp_done;
    assign status.div_done = ddone_reg;
    assign status.idx_last = idx_last;
    assign status.out_free = !mvalid_reg || m_tready;
endmodule

>>> rtl/smx_ctrl.sv
// controller: load, weight and normalize passes over the stored row
module smx_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smx_pkg::smx_status_t  status,
    output smx_pkg::smx_cmd_t     cmd
);
    import smx_pkg::*;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_EXP_RD = 3'd1;
    localparam logic [2:0] ST_EXP_GO = 3'd2;
    localparam logic [2:0] ST_EXP_WT = 3'd3;
    localparam logic [2:0] ST_NRM_RD = 3'd4;
    localparam logic [2:0] ST_NRM_GO = 3'd5;
    localparam logic [2:0] ST_NRM_WT = 3'd6;
    localparam logic [2:0] ST_NRM_OUT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                cmd.in_ready = 1'b1;
                if (status.row_done) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_EXP_RD;
                end
            end
            ST_EXP_RD: state_next = ST_EXP_GO;
            ST_EXP_GO: begin
                cmd.exp_start = 1'b1;
                state_next    = ST_EXP_WT;
            end
            ST_EXP_WT: begin
                if (status.exp_done) begin
                    cmd.wt_write = 1'b1;
                    if (status.idx_last) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_NRM_RD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_EXP_RD;
                    end
                end
            end
            ST_NRM_RD: state_next = ST_NRM_GO;
            ST_NRM_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_NRM_WT;
            end
            ST_NRM_WT: begin
                if (status.div_done) begin
                    state_next = ST_NRM_OUT;
                end
            end
            ST_NRM_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.idx_last) begin
                        cmd.row_clear = 1'b1;
                        state_next    = ST_LOAD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_NRM_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

>>> test/softmax_row_normalizer_tb.sv
// testbench for the softmax row normalizer: directed and random rows checked against a scoreboard
`timescale 1ns / 100ps

module softmax_row_normalizer_tb;
    import smx_pkg::*;

    // one expected probability item
    typedef struct {
        logic [PROB_W-1:0] prob;
        logic [POS_W-1:0]  pos;
        logic              last;
        logic              ovf;
    } prob_item_t;

    // tracks the row being loaded and the probabilities it must produce
    class row_scoreboard;
        logic signed [LOGIT_W-1:0] row_vals [64];
        int                        row_len;
        logic signed [LOGIT_W-1:0] peak;
        bit                        dropped;
        prob_item_t                due_q [$];
        logic [63:0]               exp_one;
        int                        mismatches;

        function new();
            exp_one    = exp_neg(64'd1 << 60);
            mismatches = 0;
            clear_row();
        endfunction

        function void clear_row();
            row_len = 0;
            peak    = -16'sd32768;
            dropped = 0;
        endfunction

        // floor(a * b / 2^60) from a full-width product
        function logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = a * b;
            return p[123:60];
        endfunction

        // exp(-y), y in q60, by a truncated alternating series
        function logic [63:0] exp_neg(logic [63:0] y);
            logic [63:0] term, acc;
            term = 64'd1 << 60;
            acc  = 64'd1 << 60;
            for (int k = 1; k <= 20; k++) begin
                term = q60_mul(term, y) / k;
                if (k % 2 == 1) acc = (term > acc) ? 64'd0 : acc - term;
                else acc = acc + term;
            end
            return acc;
        endfunction

        // unnormalized weight for a distance below the row peak
        function logic [15:0] weight_of(int unsigned gap);
            int unsigned whole;
            logic [63:0] v, w;
            whole = gap >> 8;
            if (whole > MAX_Q) return 16'd0;
            v = exp_neg(64'(gap & 255) << 52);
            for (int i = 0; i < whole; i++) v = q60_mul(v, exp_one);
            w = (v + (64'd1 << 43)) >> 44;
            return (w > 64'd65535) ? 16'hFFFF : w[15:0];
        endfunction

        // note an accepted logit item, predicting the row on its end mark
        function void note_logit(logic [15:0] raw, logic row_end);
            logic [15:0]        wts [64];
            logic [TOTAL_W-1:0] total;
            logic [63:0]        p;
            prob_item_t         it;
            if (row_len < 64) begin
                row_vals[row_len] = raw;
                row_len++;
                if ($signed(raw) > peak) peak = raw;
            end else begin
                dropped = 1;
            end
            if (!row_end) return;
            total = '0;
            for (int k = 0; k < row_len; k++) begin
                wts[k] = weight_of(int'(peak) - int'(row_vals[k]));
                total  = total + wts[k];
            end
            for (int k = 0; k < row_len; k++) begin
                p = ((64'(wts[k]) << 16) + (total >> 1)) / total;
                it.prob = (p > 64'd65535) ? 16'hFFFF : p[15:0];
                it.pos  = k[POS_W-1:0];
                it.last = (k + 1 == row_len);
                it.ovf  = dropped;
                due_q.push_back(it);
            end
            clear_row();
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_prob(logic [23:0] data, logic last, logic ovf);
            prob_item_t want;
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: data=%h last=%b ovf=%b", data, last, ovf);
                return;
            end
            want = due_q.pop_front();
            if (data[15:0] !== want.prob || data[21:16] !== want.pos ||
                data[23:22] !== 2'b00 || last !== want.last || ovf !== want.ovf) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp prob=%0d pos=%0d last=%b ovf=%b, got %0d %0d %b %b",
                             want.prob, want.pos, want.last, want.ovf,
                             data[15:0], data[21:16], last, ovf);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    row_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_on = 0;
    int items_sent = 0;

    softmax_row_normalizer dut (.*);

    // clock
    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // monitors on both channels
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_logit(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_prob(m_tdata, m_tlast, m_tuser);
    end

    // receiver with random stalls and long hold-offs
    always @(negedge aclk) begin
        if (hold_on) begin
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hold the receiver off while the sender keeps offering items
    initial begin
        wait (items_sent >= 20);
        @(posedge aclk);
        hold_on = 1;
        repeat (600) @(posedge aclk);
        hold_on = 0;
        wait (items_sent >= 150);
        @(posedge aclk);
        hold_on = 1;
        repeat (400) @(posedge aclk);
        hold_on = 0;
    end

    // offer one logit item, entered and left at a falling edge
    task automatic send_logit(logic [15:0] v, logic row_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= v;
        s_tlast  <= row_end;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_row(logic [15:0] vals [$]);
        foreach (vals[i]) send_logit(vals[i], i == vals.size() - 1);
    endtask

    // random row: mostly clustered logits, some over the full range
    task automatic send_random_row(int len);
        logic [15:0] vals [$];
        int base, v;
        bit wide;
        base = $urandom_range(65535) - 32768;
        wide = ($urandom_range(99) < 30);
        for (int i = 0; i < len; i++) begin
            if (wide) begin
                v = $urandom_range(65535);
            end else begin
                v = base + $urandom_range(3200) - 1600;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end
            vals.push_back(v[15:0]);
        end
        send_row(vals);
    endtask

    // limit
    initial begin
        #8ms;
        $display("softmax_row_normalizer_tb: FAIL");
        $finish;
    end

    initial begin
        int rows;
        int len;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed rows: single element, extremes, ties, cutoff of the weight
        send_row('{16'h0064});
        send_row('{16'h7FFF, 16'h8000});
        send_row('{16'h8000, 16'h8000});
        send_row('{16'h0000, 16'h0000, 16'h0000});
        send_row('{16'h0100, 16'h0000, 16'hFF00, 16'hF500, 16'hF400, 16'hF3FF});
        send_row('{16'hAAAA, 16'h5555, 16'h7FFF});
        send_row('{16'h00FF, 16'h0001, 16'h7FFF, 16'h7FFE});

        // random rows across the idling phases
        rows = 0;
        while (items_sent < 270) begin
            case (items_sent * 4 / 270)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (rows == 1 || rows == 6) len = 64 + $urandom_range(4);
            else if (rows == 8) len = 64;
            else if ($urandom_range(99) < 80) len = $urandom_range(1, 10);
            else len = $urandom_range(11, 40);
            send_random_row(len);
            rows++;
        end
        s_tvalid <= 0;

        // drain
        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("softmax_row_normalizer_tb: PASS");
        end else begin
            $display("softmax_row_normalizer_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/smx_pkg.sv
rtl/smx_ram.sv
rtl/smx_exp_unit.sv
rtl/smx_datapath.sv
rtl/smx_ctrl.sv
rtl/softmax_row_normalizer.sv
test/softmax_row_normalizer_tb.sv
